// ===== src/atdc_pkg.sv =====
// Shared types and constants for the top-k dark channel airlight estimator.
// No dependencies; every module of the block imports this package.
package atdc_pkg;

   localparam int MAX_TOP   = 512;
   localparam int CFG_W     = 10;
   localparam int CNT_W     = $clog2(MAX_TOP + 1);
   localparam int CAP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int CHAN_W    = 8;
   localparam int COLOUR_W  = 3 * CHAN_W;
   localparam int SUM_W     = CHAN_W + 2;

   localparam logic [CFG_W-1:0] TOP_COUNT_RESET = CFG_W'(307);

   typedef struct packed {
      logic                valid;
      logic [CHAN_W-1:0]   dark;
      logic [COLOUR_W-1:0] colour;
   } entry_type;

   typedef struct packed {
      logic                insert;
      logic                drain;
      logic [CHAN_W-1:0]   dark;
      logic [COLOUR_W-1:0] colour;
   } cell_ctrl_type;

endpackage

// ===== src/atdc_cell.sv =====
// One cell of the ranked list: holds a single entry and trades it with its neighbors.
// Depends on atdc_pkg for the entry and control types.
module atdc_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  atdc_pkg::cell_ctrl_type ctrl,
   input  logic                   enable,
   input  atdc_pkg::entry_type    left_entry,
   input  logic                   left_keep,
   input  atdc_pkg::entry_type    right_entry,
   output atdc_pkg::entry_type    entry_out,
   output logic                   keep_out
);
   import atdc_pkg::*;

   logic                valid_ff, valid_in;
   logic [CHAN_W-1:0]   dark_ff, dark_in;
   logic [COLOUR_W-1:0] colour_ff, colour_in;
   logic                live;

   // An entry beyond the current capacity does not count as part of the list.
   assign live      = valid_ff & enable;
   assign keep_out  = live & (dark_ff >= ctrl.dark);
   assign entry_out = '{valid: live, dark: dark_ff, colour: colour_ff};

   always_comb begin
      valid_in  = valid_ff;
      dark_in   = dark_ff;
      colour_in = colour_ff;
      if (ctrl.insert) begin
         if (!enable) begin
            valid_in = 1'b0;
         end else if (!keep_out) begin
            if (left_keep) begin
               valid_in  = 1'b1;
               dark_in   = ctrl.dark;
               colour_in = ctrl.colour;
            end else begin
               valid_in  = left_entry.valid;
               dark_in   = left_entry.dark;
               colour_in = left_entry.colour;
            end
         end
      end else if (ctrl.drain) begin
         valid_in  = right_entry.valid;
         dark_in   = right_entry.dark;
         colour_in = right_entry.colour;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      dark_ff   <= dark_in;
      colour_ff <= colour_in;
   end

endmodule

// ===== src/atdc_scan.sv =====
// Running search for the first entry with the strictly largest B+G+R sum.
// Depends on atdc_pkg for widths.
module atdc_scan (
   input  logic                          clock,
   input  logic                          load,
   input  logic [atdc_pkg::COLOUR_W-1:0] load_colour,
   input  logic                          step,
   input  logic [atdc_pkg::COLOUR_W-1:0] step_colour,
   output logic [atdc_pkg::COLOUR_W-1:0] best_colour
);
   import atdc_pkg::*;

   logic [SUM_W-1:0]    best_sum_ff, best_sum_in;
   logic [COLOUR_W-1:0] best_colour_ff, best_colour_in;
   logic [SUM_W-1:0]    step_sum;

   assign step_sum = SUM_W'(step_colour[3*CHAN_W-1:2*CHAN_W])
                   + SUM_W'(step_colour[2*CHAN_W-1:CHAN_W])
                   + SUM_W'(step_colour[CHAN_W-1:0]);

   always_comb begin
      best_sum_in    = best_sum_ff;
      best_colour_in = best_colour_ff;
      if (load) begin
         best_sum_in    = '0;
         best_colour_in = load_colour;
      end else if (step && (step_sum > best_sum_ff)) begin
         best_sum_in    = step_sum;
         best_colour_in = step_colour;
      end
   end

   always_ff @(posedge clock) begin
      best_sum_ff    <= best_sum_in;
      best_colour_ff <= best_colour_in;
   end

   assign best_colour = best_colour_ff;

endmodule

// ===== src/airlight_topk_dark_channel.sv =====
// Top level of the dark channel airlight estimator: control, capacity and result register.
// Depends on atdc_pkg, atdc_cell and atdc_scan.
//
// Usage:
//   Pixels enter on the req_ channel in raster order, one transfer per pixel, with
//   req_last_pixel marking the final pixel of a frame. Each pixel's dark value
//   (the smallest of its three channels) is ranked into a chain of MAX_TOP cells
//   that holds the top_count largest dark values in descending order, stably.
//   A pixel that is not the last of its frame leaves req_ready high, and a new transfer
//   can be made every clock. The last pixel is ranked in its transfer cycle; then the
//   chain shifts toward its head one entry per cycle while the head is scored by B+G+R.
//   req_ready is low after the last pixel's transfer until the result is loaded into the
//   rsp_ output register. The shift empties the chain, so the next frame starts clean.
//   The result waits in its register while rsp_ready is low; further pixels are
//   taken meanwhile, and only a second frame end stalls until the first result goes.
//   csr_wr_en writes top_count (0 acts as 1, values above MAX_TOP act as MAX_TOP);
//   it takes effect for the next pixel.
//   Reset empties the chain, drops any pending result and sets top_count to 307.
module airlight_topk_dark_channel (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_pixel_blue,
   input  logic [7:0]                  req_pixel_green,
   input  logic [7:0]                  req_pixel_red,
   input  logic                        req_last_pixel,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_air_blue,
   output logic [7:0]                  rsp_air_green,
   output logic [7:0]                  rsp_air_red,
   input  logic                        csr_wr_en,
   input  logic [atdc_pkg::CFG_W-1:0]  csr_wr_data
);
   import atdc_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic                state_ff, state_in;
   logic [CFG_W-1:0]    top_count_ff;
   logic [COLOUR_W-1:0] first_colour_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COLOUR_W-1:0] rsp_colour_ff;

   logic                accept;
   logic                finish;
   logic                rsp_free;
   logic [CHAN_W-1:0]   pixel_dark;
   logic [CHAN_W-1:0]   min_bg;
   logic [COLOUR_W-1:0] pixel_colour;
   logic [CAP_W-1:0]    cap_raw;
   logic [CAP_W-1:0]    cap_eff;
   cell_ctrl_type       ctrl;
   logic [COLOUR_W-1:0] best_colour;
   logic [COLOUR_W-1:0] frame_first;

   entry_type           entry_q [MAX_TOP];
   logic                keep_q  [MAX_TOP];
   logic [MAX_TOP-1:0]  valid_vec;

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid & req_ready;
   assign rsp_free     = ~rsp_valid_ff | rsp_ready;
   assign finish       = (state_ff == ST_DRAIN) & ~entry_q[0].valid & rsp_free;

   assign min_bg       = (req_pixel_blue < req_pixel_green) ? req_pixel_blue : req_pixel_green;
   assign pixel_dark   = (min_bg > req_pixel_red) ? req_pixel_red : min_bg;
   assign pixel_colour = {req_pixel_blue, req_pixel_green, req_pixel_red};

   // Effective capacity, clamped to the range the chain can hold.
   always_comb begin
      cap_raw = CAP_W'(top_count_ff);
      if (cap_raw == '0) begin
         cap_eff = CAP_W'(1);
      end else if (cap_raw > CAP_W'(MAX_TOP)) begin
         cap_eff = CAP_W'(MAX_TOP);
      end else begin
         cap_eff = cap_raw;
      end
   end

   assign ctrl = '{insert: accept,
                   drain:  (state_ff == ST_DRAIN) & entry_q[0].valid,
                   dark:   pixel_dark,
                   colour: pixel_colour};

   // The chain itself. The new pixel lands behind every entry whose dark value
   // is at least as large; entries after it move one cell toward the tail.
   for (genvar i = 0; i < MAX_TOP; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_keep;

      if (i == 0) begin : g_head
         assign left_entry = '{valid: 1'b0, dark: '0, colour: '0};
         assign left_keep  = 1'b1;
      end else begin : g_body
         assign left_entry = entry_q[i-1];
         assign left_keep  = keep_q[i-1];
      end

      if (i == MAX_TOP - 1) begin : g_tail
         assign right_entry = '{valid: 1'b0, dark: '0, colour: '0};
      end else begin : g_inner
         assign right_entry = entry_q[i+1];
      end

      atdc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .enable      (CAP_W'(i) < cap_eff),
         .left_entry  (left_entry),
         .left_keep   (left_keep),
         .right_entry (right_entry),
         .entry_out   (entry_q[i]),
         .keep_out    (keep_q[i])
      );

      assign valid_vec[i] = entry_q[i].valid;
   end

   // A frame's first pixel is the one that arrives while the list is empty.
   assign frame_first = entry_q[0].valid ? first_colour_ff : pixel_colour;

   atdc_scan u_scan (
      .clock       (clock),
      .load        (accept & req_last_pixel),
      .load_colour (frame_first),
      .step        (ctrl.drain),
      .step_colour (entry_q[0].colour),
      .best_colour (best_colour)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_pixel) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         top_count_ff <= TOP_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            top_count_ff <= csr_wr_data;
         end
      end
      if (accept && !entry_q[0].valid) begin
         first_colour_ff <= pixel_colour;
      end
      if (finish) begin
         rsp_colour_ff <= best_colour;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_air_blue  = rsp_colour_ff[3*CHAN_W-1:2*CHAN_W];
   assign rsp_air_green = rsp_colour_ff[2*CHAN_W-1:CHAN_W];
   assign rsp_air_red   = rsp_colour_ff[CHAN_W-1:0];

   // A frame end always starts the drain of the chain.
   a_last_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_pixel) |=> (state_ff == ST_DRAIN))
      else $error("frame end did not start the drain");

   // Entries are packed at the head: an empty head cell means an empty chain.
   a_chain_packed: assert property (@(posedge clock) disable iff (reset)
      (!entry_q[0].valid) |-> (valid_vec == '0))
      else $error("chain holds an entry behind an empty head cell");

   // A result appears only at the end of a drain.
   a_result_from_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DRAIN))
      else $error("result raised outside a drain");

   // No pixel is taken while the chain is draining.
   a_no_accept_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> !accept)
      else $error("pixel taken during drain");

endmodule
